// ===== rtl/core/temperature_pid_heater_drive_defines.svh =====
// Assertion macros for the temperature PID heater drive.
// Used by the port checker; it expects clk_i and rst_ni in scope.
`ifndef TEMPERATURE_PID_HEATER_DRIVE_DEFINES_SVH
`define TEMPERATURE_PID_HEATER_DRIVE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TPHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tphd_pkg.sv =====
// Shared types and constants for the temperature PID heater drive.
// No dependencies; imported by every RTL module of the block but the checker.
package tphd_pkg;

  typedef enum logic [1:0] {
    RegSetpoint = 2'd0,
    RegGainP    = 2'd1,
    RegGainI    = 2'd2,
    RegGainD    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MulP = 2'd0,
    MulD = 2'd1,
    MulI = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
  } cfg_t;

  typedef struct packed {
    logic     load;      // capture error of a new beat
    mul_sel_e mul_sel;   // multiplier operand pair
    logic     acc_clr;   // acc = product
    logic     acc_add;   // acc += product
    logic     upd;       // update delta, sum, history
    logic     scale;     // scaled = acc * 500
    logic     out_load;  // load output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Register reset values
  localparam logic [15:0] SetpointRst = 16'd11520;
  localparam logic [15:0] GainPRst    = 16'd3840;
  localparam logic [15:0] GainIRst    = 16'd6400;
  localparam logic [15:0] GainDRst    = 16'd0;

  // Q8.8 thresholds
  localparam logic signed [17:0] DeltaHi   = 18'sd512;
  localparam logic signed [17:0] DeltaLo   = -18'sd512;
  localparam logic signed [17:0] SumHi     = 18'sd1280;
  localparam logic signed [17:0] SumLoInt  = -18'sd512;
  localparam logic signed [16:0] WinHi     = 17'sd768;
  localparam logic signed [16:0] WinLo     = -17'sd768;
  localparam logic signed [16:0] ForceHi   = 17'sd1280;
  localparam logic signed [16:0] ForceLo   = -17'sd512;

  // Output values
  localparam logic [11:0] OutMax = 12'd2500;
  localparam logic [11:0] OutNeg = 12'd400;
  localparam logic [11:0] OutMin = 12'd0;

endpackage

// ===== rtl/core/tphd_regs.sv =====
// APB register file holding setpoint and the three gains.
// Depends on tphd_pkg.
module tphd_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tphd_pkg::cfg_t    cfg_o
);
  import tphd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint <= SetpointRst;
      cfg_q.gain_p   <= GainPRst;
      cfg_q.gain_i   <= GainIRst;
      cfg_q.gain_d   <= GainDRst;
    end else if (wr_en) begin
      unique case (idx)
        RegSetpoint: cfg_q.setpoint <= pwdata[15:0];
        RegGainP:    cfg_q.gain_p   <= pwdata[15:0];
        RegGainI:    cfg_q.gain_i   <= pwdata[15:0];
        RegGainD:    cfg_q.gain_d   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSetpoint: prdata = {16'd0, cfg_q.setpoint};
      RegGainP:    prdata = {16'd0, cfg_q.gain_p};
      RegGainI:    prdata = {16'd0, cfg_q.gain_i};
      RegGainD:    prdata = {16'd0, cfg_q.gain_d};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tphd_ctrl.sv =====
// Sequencer for one sample: error capture, three multiply passes,
// scaling and output load. Depends on tphd_pkg.
module tphd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  tphd_pkg::dp_status_t  status_i,
  output tphd_pkg::cmd_t        cmd_o,
  output logic                  busy_o
);
  import tphd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMulP  = 3'd1;
  localparam logic [2:0] StMulD  = 3'd2;
  localparam logic [2:0] StMulI  = 3'd3;
  localparam logic [2:0] StScale = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMulP;
        end
      end
      StMulP: begin
        cmd_o.mul_sel = MulP;
        cmd_o.acc_clr = 1'b1;
        cmd_o.upd     = 1'b1;
        state_d       = StMulD;
      end
      StMulD: begin
        cmd_o.mul_sel = MulD;
        cmd_o.acc_add = 1'b1;
        state_d       = StMulI;
      end
      StMulI: begin
        cmd_o.mul_sel = MulI;
        cmd_o.acc_add = 1'b1;
        state_d       = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StDone;
      end
      StDone: begin
        // wait for room in the output register
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tphd_dp.sv =====
// PID datapath: error, clamped delta and sum, one shared 17x17
// multiplier with accumulator, x500 scaling, output register. Uses tphd_pkg.
module tphd_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tphd_pkg::cfg_t        cfg_i,
  input  logic signed [15:0]    temperature_i,
  input  tphd_pkg::cmd_t        cmd_i,
  output tphd_pkg::dp_status_t  status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [11:0]           heater_drive_o
);
  import tphd_pkg::*;

  logic signed [16:0] err_q, err_d;
  logic signed [16:0] prev_err_q;
  logic signed [11:0] err_sum_q, err_sum_d;
  logic signed [10:0] delta_q, delta_d;
  logic               win_q, win_d;
  logic               force_hi_q, force_lo_q;
  logic signed [34:0] acc_q, prod_ext;
  logic signed [43:0] scaled_q, scaled_d, acc_ext;
  logic               out_valid_q;
  logic [11:0]        drive_q, drive_d;

  logic signed [17:0] diff, sum_raw;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic               add_en;
  logic [27:0]        whole;

  assign err_d = $signed({cfg_i.setpoint[15], cfg_i.setpoint})
               - $signed({temperature_i[15], temperature_i});

  // delta and sum from the captured error
  assign diff    = $signed({err_q[16], err_q}) - $signed({prev_err_q[16], prev_err_q});
  assign sum_raw = $signed({{6{err_sum_q[11]}}, err_sum_q}) + $signed({err_q[16], err_q});
  assign win_d   = (err_q > WinLo) && (err_q < WinHi);

  always_comb begin
    if (diff > DeltaHi) begin
      delta_d = DeltaHi[10:0];
    end else if (diff < DeltaLo) begin
      delta_d = DeltaLo[10:0];
    end else begin
      delta_d = diff[10:0];
    end
  end

  // outside the window the sum is dropped; inside, it is clamped to [-2,5]
  always_comb begin
    if (!win_d) begin
      err_sum_d = '0;
    end else if (sum_raw > SumHi) begin
      err_sum_d = SumHi[11:0];
    end else if (sum_raw < SumLoInt) begin
      err_sum_d = SumLoInt[11:0];
    end else begin
      err_sum_d = sum_raw[11:0];
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MulP: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, cfg_i.gain_p});
      end
      MulD: begin
        mul_a = $signed({{6{delta_q[10]}}, delta_q});
        mul_b = $signed({1'b0, cfg_i.gain_d});
      end
      MulI: begin
        mul_a = $signed({{5{err_sum_q[11]}}, err_sum_q});
        mul_b = $signed({1'b0, cfg_i.gain_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = $signed({prod[33], prod});
  assign add_en   = cmd_i.acc_add && ((cmd_i.mul_sel != MulI) || win_q);

  // x500 = x512 - x8 - x4
  assign acc_ext  = $signed({{9{acc_q[34]}}, acc_q});
  assign scaled_d = (acc_ext <<< 9) - (acc_ext <<< 3) - (acc_ext <<< 2);

  assign whole = scaled_q[43:16];

  always_comb begin
    if (force_lo_q) begin
      drive_d = OutMin;
    end else if (force_hi_q) begin
      drive_d = OutMax;
    end else if (scaled_q[43]) begin
      drive_d = OutNeg;
    end else if (whole > {16'd0, OutMax}) begin
      drive_d = OutMax;
    end else begin
      drive_d = whole[11:0];
    end
  end

  // kept state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q  <= '0;
      err_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        prev_err_q <= err_q;
        err_sum_q  <= err_sum_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= err_d;
    end
    if (cmd_i.upd) begin
      delta_q    <= delta_d;
      win_q      <= win_d;
      force_hi_q <= (err_q > ForceHi);
      force_lo_q <= (err_q < ForceLo);
    end
    if (cmd_i.acc_clr) begin
      acc_q <= prod_ext;
    end else if (add_en) begin
      acc_q <= acc_q + prod_ext;
    end
    if (cmd_i.scale) begin
      scaled_q <= scaled_d;
    end
    if (cmd_i.out_load) begin
      drive_q <= drive_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign heater_drive_o    = drive_q;

endmodule

// ===== rtl/core/temperature_pid_heater_drive.sv =====
// Temperature PID heater drive: one signed Q8.8 temperature beat in, one
// 12-bit heater drive beat (0..2500) out. Error = setpoint - temperature;
// the error change is clamped to +-2.0 and the kept error sum to [-2,5],
// with the integral term used, when |error| < 3.0, else the sum is
// cleared. The PID total is scaled by 500, truncated and capped at 2500; a
// negative total gives 400; error above 5.0 forces 2500, below -2.0 forces 0.
// After a sample is accepted, the error is captured at the accepting edge,
// then come three passes of the single shared 17x17 multiplier (P, D, I),
// the x500 scale and the output register load, which waits while the output
// is stalled with a result still held. The next sample can be accepted in
// the first cycle in which the result is valid, so a new sample is taken only
// once the last one has reached the output register; a finished result waits in
// the output register while the next sample is accepted. Registers sit on an
// APB port at byte addresses 0 (setpoint), 4 (Kp), 8 (Ki), 12 (Kd), all
// 16 bits, and should only be written while no sample is in flight.
module temperature_pid_heater_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] temperature_i,
  // drive out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [11:0]        heater_drive_o
);
  import tphd_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;
  logic       busy;

  tphd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: idle state is the only one that takes a beat
  tphd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  tphd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .temperature_i  (temperature_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .heater_drive_o (heater_drive_o)
  );

  assign in_stall_o = busy;

endmodule

// ===== rtl/core/tphd_checker.sv =====
// Port-level checker for the temperature PID heater drive, bound to the
// top level. Uses the assertion macros of the block's defines header.
`include "temperature_pid_heater_drive_defines.svh"

module tphd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [11:0]        heater_drive_o
);

  // drive never leaves its range
  `TPHD_ASSERT_NOW(a_drive_max, out_valid_o, heater_drive_o <= 12'd2500, "drive above 2500")

  // a stalled result stays
  `TPHD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(heater_drive_o), "stalled result changed")

  // an accepted sample keeps the block busy next cycle
  `TPHD_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // a new result only comes from a sample in flight
  `TPHD_ASSERT_NOW(a_out_from_busy, $rose(out_valid_o), $past(in_stall_o), "result without work")

endmodule

bind temperature_pid_heater_drive tphd_checker u_tphd_checker (.*);
